[rtl/hbs_pkg.sv]
`timescale 1ns / 1ps

package hbs_pkg;

  // Grid store geometry.
  localparam int GRID_AW    = 16;
  localparam int GRID_DEPTH = 65536;

  // Field widths of the item ports.
  localparam int SAMPLE_W = 8;
  localparam int COORD_W  = 24;
  localparam int SCALE_W  = 16;
  localparam int HEIGHT_W = 24;

  // Height scale after reset is 1.0 in unsigned Q8.8.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // Item command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Cycles from an accepted query to its result strobe.
  localparam int PIPE_LATENCY = 6;

  // Control bits that travel with each item down the front stages.
  typedef struct packed {
    logic vld;
    logic is_query;
  } hbs_ctl_t;

endpackage

[rtl/hbs_ram.sv]
`timescale 1ns / 1ps

// Generic RAM: one write port, two read ports, registered read data.
module hbs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 65536,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[rtl/hbs_addr.sv]
`timescale 1ns / 1ps

// Front stages: clamp and split the coordinates, then form the cell base address.
module hbs_addr import hbs_pkg::*; #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_LENGTH = 256,
  parameter int FRAC_BITS  = 8,
  localparam int IX_W = $clog2(MAP_WIDTH),
  localparam int IZ_W = $clog2(MAP_LENGTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic                       in_command,
  input  logic [GRID_AW-1:0]         in_sample_address,
  input  logic [SAMPLE_W-1:0]        in_sample_value,
  input  logic signed [COORD_W-1:0]  in_coord_x,
  input  logic signed [COORD_W-1:0]  in_coord_z,
  output hbs_ctl_t                   s2_ctl,
  output logic [GRID_AW-1:0]         s2_base,
  output logic [FRAC_BITS-1:0]       s2_fx,
  output logic [FRAC_BITS-1:0]       s2_fz,
  output logic [GRID_AW-1:0]         s2_waddr,
  output logic [SAMPLE_W-1:0]        s2_wdata
);

  localparam int EXT_W = 48;
  localparam int XC_W  = IX_W + FRAC_BITS;
  localparam int ZC_W  = IZ_W + FRAC_BITS;
  localparam logic signed [EXT_W-1:0] X_HI = EXT_W'((MAP_WIDTH - 2) * (2 ** FRAC_BITS));
  localparam logic signed [EXT_W-1:0] Z_HI = EXT_W'((MAP_LENGTH - 2) * (2 ** FRAC_BITS));

  logic signed [EXT_W-1:0] x_ext;
  logic signed [EXT_W-1:0] z_ext;
  logic [XC_W-1:0]         x_cl;
  logic [ZC_W-1:0]         z_cl;

  hbs_ctl_t                s1_ctl_r;
  logic [XC_W-1:0]         s1_x_r;
  logic [ZC_W-1:0]         s1_z_r;
  logic [GRID_AW-1:0]      s1_waddr_r;
  logic [SAMPLE_W-1:0]     s1_wdata_r;

  logic [IX_W-1:0]         ix;
  logic [IZ_W-1:0]         iz;
  logic [31:0]             base_full;

  hbs_ctl_t                s2_ctl_r;
  logic [GRID_AW-1:0]      s2_base_r;
  logic [FRAC_BITS-1:0]    s2_fx_r;
  logic [FRAC_BITS-1:0]    s2_fz_r;
  logic [GRID_AW-1:0]      s2_waddr_r;
  logic [SAMPLE_W-1:0]     s2_wdata_r;

  // Saturate each coordinate to the last cell edge; negatives read as zero.
  always_comb begin
    x_ext = EXT_W'(in_coord_x);
    z_ext = EXT_W'(in_coord_z);
    if (x_ext[EXT_W-1]) begin
      x_cl = '0;
    end else if (x_ext > X_HI) begin
      x_cl = X_HI[XC_W-1:0];
    end else begin
      x_cl = x_ext[XC_W-1:0];
    end
    if (z_ext[EXT_W-1]) begin
      z_cl = '0;
    end else if (z_ext > Z_HI) begin
      z_cl = Z_HI[ZC_W-1:0];
    end else begin
      z_cl = z_ext[ZC_W-1:0];
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r.vld      <= in_take;
      s1_ctl_r.is_query <= in_take && (in_command == CMD_QUERY);
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    s1_x_r     <= x_cl;
    s1_z_r     <= z_cl;
    s1_waddr_r <= in_sample_address;
    s1_wdata_r <= in_sample_value;
  end

  // Cell base address is row times width plus column, wrapped to the store.
  assign ix        = s1_x_r[XC_W-1:FRAC_BITS];
  assign iz        = s1_z_r[ZC_W-1:FRAC_BITS];
  assign base_full = 32'(iz) * 32'(MAP_WIDTH) + 32'(ix);

  // Stage 2 control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    s2_base_r  <= base_full[GRID_AW-1:0];
    s2_fx_r    <= s1_x_r[FRAC_BITS-1:0];
    s2_fz_r    <= s1_z_r[FRAC_BITS-1:0];
    s2_waddr_r <= s1_waddr_r;
    s2_wdata_r <= s1_wdata_r;
  end

  assign s2_ctl   = s2_ctl_r;
  assign s2_base  = s2_base_r;
  assign s2_fx    = s2_fx_r;
  assign s2_fz    = s2_fz_r;
  assign s2_waddr = s2_waddr_r;
  assign s2_wdata = s2_wdata_r;

endmodule

[rtl/hbs_lerp.sv]
`timescale 1ns / 1ps

// Back stages: lerp along x, lerp along z, then apply the height scale.
module hbs_lerp import hbs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  qv,
  input  logic [FRAC_BITS-1:0]  fx,
  input  logic [FRAC_BITS-1:0]  fz,
  input  logic [SAMPLE_W-1:0]   h00,
  input  logic [SAMPLE_W-1:0]   h10,
  input  logic [SAMPLE_W-1:0]   h01,
  input  logic [SAMPLE_W-1:0]   h11,
  input  logic [SCALE_W-1:0]    scale,
  output logic                  out_valid,
  output logic [HEIGHT_W-1:0]   out_height
);

  localparam int H0_W = SAMPLE_W + FRAC_BITS;
  localparam int LX_W = H0_W + 2;
  localparam int H_W  = SAMPLE_W + 2 * FRAC_BITS;
  localparam int LZ_W = H_W + 2;
  localparam int P_W  = H_W + SCALE_W;

  logic signed [LX_W-1:0] h00_s, h01_s, dx0_s, dx1_s, fx_s, h0_s, h1_s;
  logic [H0_W-1:0]        h0_r, h1_r;
  logic                   s4_qv_r;
  logic [FRAC_BITS-1:0]   s4_fz_r;

  logic signed [LZ_W-1:0] h0z_s, dz_s, fz_s, h_s;
  logic [H_W-1:0]         h_r;
  logic                   s5_qv_r;

  logic [P_W-1:0]         prod;
  logic [HEIGHT_W-1:0]    out_height_r;
  logic                   out_valid_r;

  // Lerp along x for the near and far rows.
  always_comb begin
    h00_s = LX_W'({1'b0, h00});
    h01_s = LX_W'({1'b0, h01});
    dx0_s = LX_W'($signed({1'b0, h10}) - $signed({1'b0, h00}));
    dx1_s = LX_W'($signed({1'b0, h11}) - $signed({1'b0, h01}));
    fx_s  = LX_W'({1'b0, fx});
    h0_s  = (h00_s <<< FRAC_BITS) + dx0_s * fx_s;
    h1_s  = (h01_s <<< FRAC_BITS) + dx1_s * fx_s;
  end

  // Lerp along z between the two row results.
  always_comb begin
    h0z_s = LZ_W'({1'b0, h0_r});
    dz_s  = LZ_W'({1'b0, h1_r}) - h0z_s;
    fz_s  = LZ_W'({1'b0, s4_fz_r});
    h_s   = (h0z_s <<< FRAC_BITS) + dz_s * fz_s;
  end

  // Scale and keep eight fraction bits.
  assign prod = P_W'(h_r) * P_W'(scale);

  // Valid bits for the back stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_qv_r     <= 1'b0;
      s5_qv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s4_qv_r     <= qv;
      s5_qv_r     <= s4_qv_r;
      out_valid_r <= s5_qv_r;
    end
  end

  // Payload of the back stages.
  always_ff @(posedge clk) begin
    h0_r         <= h0_s[H0_W-1:0];
    h1_r         <= h1_s[H0_W-1:0];
    s4_fz_r      <= fz;
    h_r          <= h_s[H_W-1:0];
    out_height_r <= prod[2 * FRAC_BITS +: HEIGHT_W];
  end

  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;

endmodule

[rtl/heightmap_bilinear_sampler.sv]
`timescale 1ns / 1ps

// Channel   Ports                                                 Handshake
// input     in_command, in_sample_address, in_sample_value,      start && !busy
//           in_coord_x, in_coord_z
// result    out_height                                            out_valid, one cycle
// config    cfg_wr_data                                           cfg_wr_en
//
// One item is taken every cycle while busy is low; busy is high only in the cycle
// after a reset cycle. Queries return their heights in item order; a write returns
// nothing. Two grid copies with two read ports each give all four samples of a cell
// in the same cycle. Reset clears the pipeline valid bits and sets the scale to 1.0;
// the grid is kept. The receiver cannot stall, so the pipeline never holds.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_LENGTH = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic [GRID_AW-1:0]        in_sample_address,
  input  logic [SAMPLE_W-1:0]       in_sample_value,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_z,
  output logic                      out_valid,
  output logic [HEIGHT_W-1:0]       out_height,
  input  logic                      cfg_wr_en,
  input  logic [SCALE_W-1:0]        cfg_wr_data
);

  localparam logic [GRID_AW-1:0] ROW_STEP = GRID_AW'(MAP_WIDTH);

  logic                 busy_r;
  logic [SCALE_W-1:0]   scale_r;
  logic                 take;

  hbs_ctl_t             s2_ctl;
  logic [GRID_AW-1:0]   s2_base;
  logic [FRAC_BITS-1:0] s2_fx;
  logic [FRAC_BITS-1:0] s2_fz;
  logic [GRID_AW-1:0]   s2_waddr;
  logic [SAMPLE_W-1:0]  s2_wdata;

  logic                 grid_we;
  logic [GRID_AW-1:0]   ra00, ra10, ra01, ra11;
  logic [SAMPLE_W-1:0]  h00, h10, h01, h11;

  logic                 s3_qv_r;
  logic [FRAC_BITS-1:0] s3_fx_r;
  logic [FRAC_BITS-1:0] s3_fz_r;

  assign take = start && !busy_r;

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Height scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  hbs_addr #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_LENGTH (MAP_LENGTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_take           (take),
    .in_command        (in_command),
    .in_sample_address (in_sample_address),
    .in_sample_value   (in_sample_value),
    .in_coord_x        (in_coord_x),
    .in_coord_z        (in_coord_z),
    .s2_ctl            (s2_ctl),
    .s2_base           (s2_base),
    .s2_fx             (s2_fx),
    .s2_fz             (s2_fz),
    .s2_waddr          (s2_waddr),
    .s2_wdata          (s2_wdata)
  );

  // Corner addresses wrap with the store; writes go to both copies.
  assign grid_we = s2_ctl.vld && !s2_ctl.is_query;
  assign ra00    = s2_base;
  assign ra10    = s2_base + GRID_AW'(1);
  assign ra01    = s2_base + ROW_STEP;
  assign ra11    = s2_base + ROW_STEP + GRID_AW'(1);

  hbs_ram #(
    .DATA_W (SAMPLE_W),
    .DEPTH  (GRID_DEPTH)
  ) u_grid_near (
    .clk     (clk),
    .we      (grid_we),
    .waddr   (s2_waddr),
    .wdata   (s2_wdata),
    .raddr_a (ra00),
    .raddr_b (ra10),
    .rdata_a (h00),
    .rdata_b (h10)
  );

  hbs_ram #(
    .DATA_W (SAMPLE_W),
    .DEPTH  (GRID_DEPTH)
  ) u_grid_far (
    .clk     (clk),
    .we      (grid_we),
    .waddr   (s2_waddr),
    .wdata   (s2_wdata),
    .raddr_a (ra01),
    .raddr_b (ra11),
    .rdata_a (h01),
    .rdata_b (h11)
  );

  // Stage 3 carries the fractions alongside the grid read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_qv_r <= 1'b0;
    end else begin
      s3_qv_r <= s2_ctl.vld && s2_ctl.is_query;
    end
  end

  always_ff @(posedge clk) begin
    s3_fx_r <= s2_fx;
    s3_fz_r <= s2_fz;
  end

  hbs_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk        (clk),
    .rst_n      (rst_n),
    .qv         (s3_qv_r),
    .fx         (s3_fx_r),
    .fz         (s3_fz_r),
    .h00        (h00),
    .h10        (h10),
    .h01        (h01),
    .h11        (h11),
    .scale      (scale_r),
    .out_valid  (out_valid),
    .out_height (out_height)
  );

  assign busy = busy_r;

endmodule

[rtl/hbs_checker.sv]
`timescale 1ns / 1ps

// Port-level checks on item flow through the sampler.
module hbs_checker import hbs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_command,
  input logic out_valid
);

  logic                    acc_query;
  logic [PIPE_LATENCY-1:0] run_hist_r;

  assign acc_query = start && !busy && (in_command == CMD_QUERY);

  // History of reset being released, one bit per past cycle.
  always_ff @(posedge clk) begin
    run_hist_r <= {run_hist_r[PIPE_LATENCY-2:0], rst_n};
  end

  // Once out of reset, busy stays low, so every offered item is taken.
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");

  // Every result stems from a query taken a fixed time earlier.
  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_query, PIPE_LATENCY))
    else $error("result without a matching query");

  // Every query taken without an intervening reset yields a result.
  a_query_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(acc_query, PIPE_LATENCY) && (&run_hist_r)) |-> out_valid)
    else $error("query lost in the pipeline");

  // Reset flushes pending results, so the first cycle out of reset shows none.
  a_reset_flush: assert property (@(posedge clk)
    (!$past(rst_n) && rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);

[bench/height_lookup_monitor.sv]
`timescale 1ns / 1ps

// Watches the item, result and configuration ports of the height sampler.
// It keeps its own copy of the grid and the scale, predicts the height of
// every accepted query and compares each result strobe with the oldest one.
module height_lookup_monitor import hbs_pkg::*; #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_LENGTH = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_command,
  input  logic [GRID_AW-1:0]        in_sample_address,
  input  logic [SAMPLE_W-1:0]       in_sample_value,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic                      out_valid,
  input  logic [HEIGHT_W-1:0]       out_height,
  input  logic                      cfg_wr_en,
  input  logic [SCALE_W-1:0]        cfg_wr_data,
  output int                        fail_count,
  output int                        pending_count
);

  // Shadow copy of the grid and of the scale register.
  logic [SAMPLE_W-1:0] level_store [GRID_DEPTH];
  logic [SCALE_W-1:0]  scale_now;

  // Heights of accepted queries that have not come out yet, oldest first.
  logic [HEIGHT_W-1:0] heights_due [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    scale_now     = SCALE_RESET;
  end

  // Saturate a coordinate to the first and last cell edge.
  function automatic longint clamp_to_map(input logic signed [COORD_W-1:0] v,
                                          input longint cells);
    longint edge_hi;
    longint vv;
    edge_hi = cells * (longint'(1) << FRAC_BITS);
    vv      = v;
    if (vv < 0) return 0;
    if (vv > edge_hi) return edge_hi;
    return vv;
  endfunction

  // Grid read; the address wraps to the size of the store.
  function automatic longint level_at(input longint col, input longint row);
    logic [GRID_AW-1:0] addr;
    addr = GRID_AW'(row * MAP_WIDTH + col);
    return longint'(level_store[addr]);
  endfunction

  // Bilinear height of a query, scaled and truncated to Q16.8.
  function automatic logic [HEIGHT_W-1:0] bilinear_height(
      input logic signed [COORD_W-1:0] cx,
      input logic signed [COORD_W-1:0] cz);
    longint x_fix, z_fix, col, row, fx, fz, one;
    longint h00, h10, h01, h11, h0, h1, h;
    longint prod;
    one   = longint'(1) << FRAC_BITS;
    x_fix = clamp_to_map(cx, MAP_WIDTH - 2);
    z_fix = clamp_to_map(cz, MAP_LENGTH - 2);
    col   = x_fix >> FRAC_BITS;
    row   = z_fix >> FRAC_BITS;
    fx    = x_fix & (one - 1);
    fz    = z_fix & (one - 1);
    h00   = level_at(col, row);
    h10   = level_at(col + 1, row);
    h01   = level_at(col, row + 1);
    h11   = level_at(col + 1, row + 1);
    // Lerp along x first, then along z; the sum carries twice the fraction bits.
    h0    = h00 * one + (h10 - h00) * fx;
    h1    = h01 * one + (h11 - h01) * fx;
    h     = h0 * one + (h1 - h0) * fz;
    prod  = h * longint'(scale_now);
    return HEIGHT_W'(prod >> (2 * FRAC_BITS));
  endfunction

  // Compare results first, then take in the item of this edge.
  always @(posedge clk) begin : watch
    logic [HEIGHT_W-1:0] want;
    if (!rst_n) begin
      scale_now = SCALE_RESET;
      heights_due.delete();
    end else begin
      if (out_valid) begin
        if (heights_due.size() == 0) begin
          fail_count++;
          $display("%0t: height result with no query waiting: expected none, actual %0d",
                   $time, out_height);
        end else begin
          want = heights_due.pop_front();
          if (out_height !== want) begin
            fail_count++;
            $display("%0t: height mismatch: expected %0d, actual %0d",
                     $time, want, out_height);
          end
        end
      end
      if (cfg_wr_en) begin
        scale_now = cfg_wr_data;
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE) begin
          level_store[in_sample_address] = in_sample_value;
        end else begin
          heights_due.push_back(bilinear_height(in_coord_x, in_coord_z));
        end
      end
    end
    pending_count = heights_due.size();
  end

endmodule

[bench/heightmap_bilinear_sampler_test.sv]
`timescale 1ns / 1ps

// Drives write and query items into the height sampler, changes the scale
// between phases and gives the verdict from the monitor's failure count.
module heightmap_bilinear_sampler_test;
  import hbs_pkg::*;

  localparam int MAP_W   = 256;
  localparam int MAP_L   = 256;
  localparam int FB      = 8;
  localparam int PHASES  = 6;
  localparam int PHASE_N = 125;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_command;
  logic [GRID_AW-1:0]        in_sample_address;
  logic [SAMPLE_W-1:0]       in_sample_value;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_z;
  logic                      out_valid;
  logic [HEIGHT_W-1:0]       out_height;
  logic                      cfg_wr_en;
  logic [SCALE_W-1:0]        cfg_wr_data;
  int                        fail_count;
  int                        pending_count;

  // Cells whose four corner samples have all been written, as row*MAP_W+col.
  int  filled_cells [$];
  bit  gaps_on;
  int  phase_items;

  heightmap_bilinear_sampler #(
    .MAP_WIDTH (MAP_W),
    .MAP_LENGTH(MAP_L),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_sample_address(in_sample_address),
    .in_sample_value  (in_sample_value),
    .in_coord_x       (in_coord_x),
    .in_coord_z       (in_coord_z),
    .out_valid        (out_valid),
    .out_height       (out_height),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  height_lookup_monitor #(
    .MAP_WIDTH (MAP_W),
    .MAP_LENGTH(MAP_L),
    .FRAC_BITS (FB)
  ) i_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_sample_address(in_sample_address),
    .in_sample_value  (in_sample_value),
    .in_coord_x       (in_coord_x),
    .in_coord_z       (in_coord_z),
    .out_valid        (out_valid),
    .out_height       (out_height),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case results stop coming.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one item, with an occasional gap before it, and hold it until taken.
  task automatic drive_item(input logic cmd, input logic [GRID_AW-1:0] addr,
                            input logic [SAMPLE_W-1:0] val,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] z);
    int n;
    if (gaps_on && $urandom_range(0, 99) < 3) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    in_command        = cmd;
    in_sample_address = addr;
    in_sample_value   = val;
    in_coord_x        = x;
    in_coord_z        = z;
    start             = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_sample(input int addr, input int val);
    drive_item(CMD_WRITE, GRID_AW'(addr), SAMPLE_W'(val), COORD_W'($urandom),
               COORD_W'($urandom));
  endtask

  task automatic query_height(input int x, input int z);
    drive_item(CMD_QUERY, GRID_AW'($urandom), SAMPLE_W'($urandom), COORD_W'(x),
               COORD_W'(z));
  endtask

  // Stop sending and wait until every query has come back, then let the
  // pipeline run empty behind any trailing writes.
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_W-1:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  function automatic int rand_level();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 255 : 0;
    return $urandom_range(0, 255);
  endfunction

  // Cell index along one axis, leaning toward the first and the last cell.
  function automatic int rand_cell(input int last);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? last : 0;
    return $urandom_range(0, last);
  endfunction

  // Coordinate that lands in cell c; edge cells also get far out-of-range values.
  function automatic int coord_in_cell(input int c, input int last);
    int kind;
    kind = $urandom_range(0, 9);
    if (c == 0 && kind < 3) return -int'($urandom_range(1, 8388608));
    if (c == last && kind < 3) return $urandom_range(last << FB, 8388607);
    if (kind == 3) return c << FB;
    return (c << FB) + $urandom_range(0, (1 << FB) - 1);
  endfunction

  // Write all four corners of one cell, then remember it as safe to query.
  task automatic fill_cell(input int col, input int row);
    write_sample(row * MAP_W + col, rand_level());
    write_sample(row * MAP_W + col + 1, rand_level());
    write_sample((row + 1) * MAP_W + col, rand_level());
    write_sample((row + 1) * MAP_W + col + 1, rand_level());
    filled_cells.push_back(row * MAP_W + col);
  endtask

  initial begin : stimulus
    int r, cell_id, col, row;
    logic [SCALE_W-1:0] scales [PHASES];
    rst_n             = 1'b0;
    start             = 1'b0;
    in_command        = CMD_WRITE;
    in_sample_address = '0;
    in_sample_value   = '0;
    in_coord_x        = '0;
    in_coord_z        = '0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    gaps_on           = 1'b0;
    scales = '{16'hFFFF, 16'h0000, 16'h0001, SCALE_W'($urandom), 16'h0100,
               SCALE_W'($urandom)};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset scale: the four corner cells of the map,
    // with the smallest and largest sample values.
    write_sample(0, 0);
    write_sample(1, 255);
    write_sample(MAP_W, 255);
    write_sample(MAP_W + 1, 0);
    write_sample(MAP_W - 2, 17);
    write_sample(MAP_W - 1, 200);
    write_sample(2 * MAP_W - 2, 3);
    write_sample(2 * MAP_W - 1, 128);
    write_sample((MAP_L - 2) * MAP_W, 90);
    write_sample((MAP_L - 2) * MAP_W + 1, 1);
    write_sample((MAP_L - 1) * MAP_W, 254);
    write_sample((MAP_L - 1) * MAP_W + 1, 60);
    write_sample((MAP_L - 2) * MAP_W + MAP_W - 2, 255);
    write_sample((MAP_L - 2) * MAP_W + MAP_W - 1, 255);
    write_sample((MAP_L - 1) * MAP_W + MAP_W - 2, 255);
    write_sample((MAP_L - 1) * MAP_W + MAP_W - 1, 255);
    filled_cells.push_back(0);
    filled_cells.push_back(MAP_W - 2);
    filled_cells.push_back((MAP_L - 2) * MAP_W);
    filled_cells.push_back((MAP_L - 2) * MAP_W + MAP_W - 2);

    // Exact corner, both kinds of saturation, the last edge and full fractions.
    query_height(0, 0);
    query_height(-8388608, -8388608);
    query_height(8388607, 8388607);
    query_height(8388607, -8388608);
    query_height(-8388608, 8388607);
    query_height((MAP_W - 2) << FB, (MAP_L - 2) << FB);
    query_height(((MAP_W - 2) << FB) + 1, 128);
    query_height(128, 64);
    query_height((1 << FB) - 1, (1 << FB) - 1);

    // Random phases, each at its own scale; one phase runs without gaps.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_scale(scales[p]);
      gaps_on     = (p != 2);
      phase_items = 0;
      while (phase_items < PHASE_N) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          fill_cell(rand_cell(MAP_W - 2), rand_cell(MAP_L - 2));
          phase_items += 4;
        end else if (r < 27) begin
          write_sample($urandom_range(0, GRID_DEPTH - 1), rand_level());
          phase_items++;
        end else begin
          cell_id = filled_cells[$urandom_range(0, filled_cells.size() - 1)];
          col     = cell_id % MAP_W;
          row     = cell_id / MAP_W;
          query_height(coord_in_cell(col, MAP_W - 2), coord_in_cell(row, MAP_L - 2));
          phase_items++;
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
